[src/mefd_pkg.sv]
package mefd_pkg;

	localparam int COUNTS_PER_TURN = 8192;
	localparam int ANGLE_BITS      = $clog2(COUNTS_PER_TURN);
	localparam int TURN_BITS       = 24;
	localparam int TOTAL_BITS      = TURN_BITS + ANGLE_BITS;
	localparam int DELTA_BITS      = ANGLE_BITS + 1;

	localparam int SCALE_BITS      = 16;
	localparam int SPEED_BITS      = 16;
	localparam int TORQUE_BITS     = 16;
	localparam int TEMP_BITS       = 8;
	localparam int SPEED_OUT_BITS  = 32;
	localparam int ANGLE_OUT_BITS  = TOTAL_BITS + SCALE_BITS;

	localparam int DATA_BITS       = 32;
	localparam int ADDR_BITS       = 3;
	localparam int REG_IDX_LSB     = 2;

	typedef logic        [ANGLE_BITS-1:0]     angle_t;
	typedef logic signed [TURN_BITS-1:0]      turn_t;
	typedef logic signed [TOTAL_BITS-1:0]     total_t;
	typedef logic signed [DELTA_BITS-1:0]     delta_t;
	typedef logic        [SCALE_BITS-1:0]     scale_t;
	typedef logic signed [SPEED_BITS-1:0]     speed_t;
	typedef logic signed [TORQUE_BITS-1:0]    torque_t;
	typedef logic        [TEMP_BITS-1:0]      temp_t;
	typedef logic signed [SPEED_OUT_BITS-1:0] speed_out_t;
	typedef logic signed [ANGLE_OUT_BITS-1:0] angle_out_t;

	localparam delta_t HALF_TURN     = delta_t'(COUNTS_PER_TURN / 2);
	localparam delta_t NEG_HALF_TURN = -HALF_TURN;
	localparam turn_t  TURN_MAX      = {1'b0, {(TURN_BITS - 1){1'b1}}};
	localparam turn_t  TURN_MIN      = {1'b1, {(TURN_BITS - 1){1'b0}}};

	localparam scale_t SPEED_SCALE_RST = scale_t'(6862);
	localparam scale_t ANGLE_SCALE_RST = scale_t'(2880);

	typedef enum logic {
		REG_SPEED_SCALE = 1'b0,
		REG_ANGLE_SCALE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		scale_t speed_scale;
		scale_t angle_scale;
	} scales_t;

	typedef struct packed {
		logic    restart;
		angle_t  shaft_angle;
		speed_t  raw_speed;
		torque_t raw_torque;
		temp_t   temperature;
	} feedback_t;

	typedef struct packed {
		speed_t  raw_speed;
		torque_t raw_torque;
		temp_t   temperature;
		turn_t   turns;
		total_t  total;
	} position_t;

endpackage

[src/mefd_if.sv]
interface mefd_feedback_if;
	import mefd_pkg::*;

	logic    valid;
	logic    ready;
	logic    restart;
	angle_t  shaft_angle;
	speed_t  raw_speed;
	torque_t raw_torque;
	temp_t   temperature;

	modport source (
		output valid, restart, shaft_angle, raw_speed, raw_torque, temperature,
		input  ready
	);

	modport sink (
		input  valid, restart, shaft_angle, raw_speed, raw_torque, temperature,
		output ready
	);
endinterface

interface mefd_result_if;
	import mefd_pkg::*;

	logic       valid;
	logic       ready;
	speed_out_t speed_out;
	torque_t    torque_out;
	temp_t      temperature_out;
	turn_t      turn_count;
	total_t     total_count;
	angle_out_t angle_out;

	modport source (
		output valid, speed_out, torque_out, temperature_out, turn_count, total_count,
			angle_out,
		input  ready
	);

	modport sink (
		input  valid, speed_out, torque_out, temperature_out, turn_count, total_count,
			angle_out,
		output ready
	);
endinterface

[src/mefd_cfg.sv]
module mefd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mefd_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [mefd_pkg::DATA_BITS-1:0]    pwdata,
	output logic [mefd_pkg::DATA_BITS-1:0]    prdata,
	output logic                              pready,
	output mefd_pkg::scales_t                 scales
);
	import mefd_pkg::*;

	scale_t   speed_scale_q;
	scale_t   angle_scale_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[REG_IDX_LSB]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_scale_q <= SPEED_SCALE_RST;
			angle_scale_q <= ANGLE_SCALE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SPEED_SCALE: speed_scale_q <= pwdata[SCALE_BITS-1:0];
				REG_ANGLE_SCALE: angle_scale_q <= pwdata[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SPEED_SCALE: prdata = DATA_BITS'(speed_scale_q);
			REG_ANGLE_SCALE: prdata = DATA_BITS'(angle_scale_q);
			default:         prdata = '0;
		endcase
	end

	assign scales.speed_scale = speed_scale_q;
	assign scales.angle_scale = angle_scale_q;

endmodule

[src/mefd_unwrap.sv]
module mefd_unwrap (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mefd_pkg::feedback_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mefd_pkg::position_t   out_data
);
	import mefd_pkg::*;

	logic      valid_s1;
	feedback_t fb_s1;
	logic      valid_s2;
	position_t pos_s2;

	logic      aligned_q;
	angle_t    prev_angle_q;
	turn_t     turns_q;

	logic      ready_s1;
	logic      ready_s2;
	logic      move_s1;
	delta_t    delta;
	turn_t     turns_nxt;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign move_s1  = valid_s1 && ready_s2;
	assign in_ready = ready_s1;

	assign delta = $signed({1'b0, fb_s1.shaft_angle}) - $signed({1'b0, prev_angle_q});

	// A forward jump of more than half a turn means the angle wrapped backward.
	always_comb begin
		turns_nxt = turns_q;
		if (fb_s1.restart || !aligned_q) begin
			turns_nxt = '0;
		end else if (delta > HALF_TURN) begin
			if (turns_q != TURN_MIN) begin
				turns_nxt = turns_q - turn_t'(1);
			end
		end else if (delta < NEG_HALF_TURN) begin
			if (turns_q != TURN_MAX) begin
				turns_nxt = turns_q + turn_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			aligned_q    <= 1'b0;
			prev_angle_q <= '0;
			turns_q      <= '0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (move_s1) begin
				aligned_q    <= 1'b1;
				prev_angle_q <= fb_s1.shaft_angle;
				turns_q      <= turns_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			fb_s1 <= in_data;
		end
		if (move_s1) begin
			pos_s2.raw_speed   <= fb_s1.raw_speed;
			pos_s2.raw_torque  <= fb_s1.raw_torque;
			pos_s2.temperature <= fb_s1.temperature;
			pos_s2.turns       <= turns_nxt;
			pos_s2.total       <= {turns_nxt, fb_s1.shaft_angle};
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = pos_s2;

endmodule

[src/mefd_scale.sv]
module mefd_scale (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mefd_pkg::scales_t     scales,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mefd_pkg::position_t   in_data,
	mefd_result_if.source         result
);
	import mefd_pkg::*;

	logic                                 valid_s3;
	speed_out_t                           speed_out_s3;
	torque_t                              torque_s3;
	temp_t                                temp_s3;
	turn_t                                turns_s3;
	total_t                               total_s3;
	angle_out_t                           angle_out_s3;

	logic signed [SPEED_BITS+SCALE_BITS:0] speed_prod;
	logic signed [TOTAL_BITS+SCALE_BITS:0] angle_prod;

	assign in_ready   = !valid_s3 || result.ready;
	assign speed_prod = in_data.raw_speed * $signed({1'b0, scales.speed_scale});
	assign angle_prod = in_data.total * $signed({1'b0, scales.angle_scale});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			speed_out_s3 <= speed_prod[SPEED_OUT_BITS-1:0];
			torque_s3    <= in_data.raw_torque;
			temp_s3      <= in_data.temperature;
			turns_s3     <= in_data.turns;
			total_s3     <= in_data.total;
			angle_out_s3 <= angle_prod[ANGLE_OUT_BITS-1:0];
		end
	end

	assign result.valid           = valid_s3;
	assign result.speed_out       = speed_out_s3;
	assign result.torque_out      = torque_s3;
	assign result.temperature_out = temp_s3;
	assign result.turn_count      = turns_s3;
	assign result.total_count     = total_s3;
	assign result.angle_out       = angle_out_s3;

endmodule

[src/multiturn_encoder_feedback_decoder.sv]
// Unwraps a single-turn encoder angle into a multi-turn position and scales speed
// and angle by the two Q0.16 registers. Each item passes through three register
// stages (input, unwrap, product), and the result is presented from the product
// stage; a new item is accepted every cycle while results drain.
// The clock path is set by the 37 by 17 bit angle multiply in the last stage.
// The first item after reset, or any item with restart set, resets the turn count
// to zero; a jump of more than half a turn between items steps the count, which
// saturates at its signed limits. Scale registers may only be written while no
// item is in flight.
module multiturn_encoder_feedback_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	mefd_feedback_if.sink                     feedback,
	mefd_result_if.source                     result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mefd_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [mefd_pkg::DATA_BITS-1:0]    pwdata,
	output logic [mefd_pkg::DATA_BITS-1:0]    prdata,
	output logic                              pready
);
	import mefd_pkg::*;

	scales_t   scales;
	feedback_t fb;
	position_t pos;
	logic      pos_valid;
	logic      pos_ready;

	assign fb.restart     = feedback.restart;
	assign fb.shaft_angle = feedback.shaft_angle;
	assign fb.raw_speed   = feedback.raw_speed;
	assign fb.raw_torque  = feedback.raw_torque;
	assign fb.temperature = feedback.temperature;

	mefd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.scales  (scales)
	);

	mefd_unwrap u_unwrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (feedback.valid),
		.in_ready  (feedback.ready),
		.in_data   (fb),
		.out_valid (pos_valid),
		.out_ready (pos_ready),
		.out_data  (pos)
	);

	mefd_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.scales   (scales),
		.in_valid (pos_valid),
		.in_ready (pos_ready),
		.in_data  (pos),
		.result   (result)
	);

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pos_valid && !pos_ready |=> pos_valid && $stable(pos))
		else $error("Unwrapped item changed while stalled.");

	a_total_turns: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.total_count[TOTAL_BITS-1:ANGLE_BITS] == result.turn_count)
		else $error("Total count does not match the turn count.");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> feedback.ready)
		else $error("Input stalled while the result stage is empty.");

endmodule
